// File: sv/keyword_dictionary_matcher_core_macros.svh
// assertion macros for the keyword dictionary matcher
`ifndef KEYWORD_DICTIONARY_MATCHER_CORE_MACROS_SVH
`define KEYWORD_DICTIONARY_MATCHER_CORE_MACROS_SVH
// property that must hold every cycle outside reset
`define KDM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// condition that must never be seen outside reset
`define KDM_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`endif

// File: sv/kdm_pkg.sv
// ----------------------------------------------------------------------------
// kdm_pkg
// shared types and codes of the keyword dictionary matcher
// ----------------------------------------------------------------------------
package kdm_pkg;
	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_SCAN  = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;
	localparam logic [1:0] KIND_CLEAR = 2'd3;

	localparam logic RES_SCAN = 1'b0;
	localparam logic RES_READ = 1'b1;

	// control handed from the top level into each cell
	typedef struct packed {
		logic scan;
		logic load;
		logic clr;
		logic first;
		logic last;
	} kdm_ctl_t;

	// ascii upper to lower case
	function automatic logic [7:0] fold(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5a) r = c + 8'd32;
		return r;
	endfunction
endpackage

// File: sv/kdm_cell.sv
// ----------------------------------------------------------------------------
// kdm_cell
// one keyword slot: stores the folded keyword, matches it against the window
// ----------------------------------------------------------------------------
module kdm_cell #(
	parameter int KEY_LEN = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  kdm_pkg::kdm_ctl_t ctl,
	input  logic sel,
	input  logic [$clog2(KEY_LEN+1)-1:0] pos,
	input  logic [7:0] data_byte,
	input  logic [3:0] group_in,
	input  logic [KEY_LEN*8-1:0] window,
	input  logic [23:0] have,
	output logic [3:0] group_out,
	output logic [$clog2(KEY_LEN+1)-1:0] len_out,
	output logic hit
);
	import kdm_pkg::*;
	localparam int LW = $clog2(KEY_LEN+1);

	logic [7:0] key_q [KEY_LEN];
	logic [LW-1:0] len_q;
	logic [3:0] group_q;
	logic [LW-1:0] newlen;

	// byte store, kept folded; bytes shift in with the newest at index 0
	always_ff @(posedge clk) begin
		if (ctl.load && sel) begin
			if (pos < LW'(KEY_LEN)) begin
				key_q[0] <= fold(data_byte);
				for (int i = 1; i < KEY_LEN; i++) key_q[i] <= key_q[i-1];
			end
			group_q <= group_in;
		end
	end

	always_comb begin
		newlen = (pos < LW'(KEY_LEN)) ? pos + 1'b1 : pos;
	end

	// length: zero while loading, set on the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (ctl.load && sel) begin
			if (ctl.last) len_q <= (newlen >= LW'(2)) ? newlen : '0;
			else if (ctl.first) len_q <= '0;
		end
	end

	// window[0] newest; key_q[i] holds keyword byte len-1-i and meets window[i]
	always_comb begin
		logic ok;
		ok = (len_q >= LW'(2)) && (24'(len_q) <= have);
		for (int i = 0; i < KEY_LEN; i++)
			if (LW'(i) < len_q && key_q[i] != window[i*8 +: 8])
				ok = 1'b0;
		hit = ok;
	end

	assign group_out = group_q;
	assign len_out = len_q;
endmodule

// File: sv/kdm_hits.sv
// ----------------------------------------------------------------------------
// kdm_hits
// saturating per-group hit counters
// ----------------------------------------------------------------------------
module kdm_hits #(
	parameter int GROUPS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic clr,
	input  logic inc,
	input  logic [3:0] inc_group,
	input  logic [3:0] rd_group,
	output logic [31:0] rd_count
);
	logic [31:0] cnt_q [GROUPS];

	// counter update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < GROUPS; g++) cnt_q[g] <= '0;
		end else begin
			for (int g = 0; g < GROUPS; g++) begin
				if (clr) cnt_q[g] <= '0;
				else if (inc && 32'(inc_group) == 32'(g) && cnt_q[g] != '1)
					cnt_q[g] <= cnt_q[g] + 32'd1;
			end
		end
	end

	always_comb begin
		rd_count = '0;
		for (int g = 0; g < GROUPS; g++)
			if (32'(rd_group) == 32'(g)) rd_count = cnt_q[g];
	end
endmodule

// File: sv/keyword_dictionary_matcher_core.sv
// ----------------------------------------------------------------------------
// keyword_dictionary_matcher_core
// case-insensitive multi-keyword matcher with per-group hit counters
// ----------------------------------------------------------------------------
// s_axis carries words of kind/data/last/slot/group; kind 0 loads a keyword
// byte, 1 scans a buffer byte, 2 reads a group counter, 3 clears counters.
// every keyword slot is a cell comparing its stored bytes against a shifting
// window of scan bytes, so one word is taken per cycle when the output is free.
// a scan word with tlast, or a read word, yields one m_axis word from the
// output register in the cycle after acceptance. the verdict for the final byte
// is resolved in the acceptance cycle by a priority pick over the cell hits.
// cfg writes set the active keyword count and are taken at any time.
// reset clears lengths, window, best match and counters; keyword bytes hold
// their old contents but cannot match until reloaded.
// when m_axis stalls the output register holds and s_axis_tready drops until
// the pending word is taken; words then resume at one per cycle.
// ----------------------------------------------------------------------------
module keyword_dictionary_matcher_core #(
	parameter int MAX_KEYWORDS = 64,
	parameter int MAX_KEY_LEN  = 32,
	parameter int MAX_GROUPS   = 16,
	parameter int MAX_SCAN_LEN = 65536
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [23:0] s_axis_tdata, // data_byte, key_slot, group_id, pad
	input  logic [1:0] s_axis_tuser,  // kind
	input  logic s_axis_tlast,        // last
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [63:0] m_axis_tdata, // matched, slot, group, offset, count, pad
	output logic m_axis_tuser,        // result_kind
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [6:0] cfg_data       // keyword_count
);
	import kdm_pkg::*;
	localparam int LW = $clog2(MAX_KEY_LEN+1);
	localparam int NK = (MAX_KEYWORDS < 64) ? MAX_KEYWORDS : 64;

	logic [6:0] kcount_q;
	logic [LW-1:0] lpos_q;
	logic [MAX_KEY_LEN*8-1:0] win_q;
	logic [23:0] spos_q;
	logic bfound_q;
	logic [15:0] bstart_q;
	logic [5:0] bslot_q;
	logic ovalid_q;
	logic [63:0] odata_q;
	logic ouser_q;

	logic acc;
	logic [1:0] kind;
	logic [7:0] db;
	logic [5:0] kslot;
	logic [3:0] gid;
	kdm_ctl_t ctl;
	logic doscan;
	logic [MAX_KEY_LEN*8-1:0] win_n;
	logic [23:0] have_n;
	logic [NK-1:0] hits;
	logic [3:0] grp [NK];
	logic [LW-1:0] klen [NK];
	logic [MAX_KEY_LEN:0] seen;
	logic [LW-1:0] clen;
	logic cfound;
	logic [5:0] cslot;
	logic [15:0] cstart;
	logic nfound;
	logic [15:0] nstart;
	logic [5:0] nslot;
	logic [3:0] wgroup;
	logic [31:0] rcount;
	logic [6:0] act;

	assign cfg_ready = 1'b1;
	assign s_axis_tready = !ovalid_q || m_axis_tready;
	assign acc = s_axis_tvalid && s_axis_tready;
	assign kind = s_axis_tuser;
	assign db = s_axis_tdata[7:0];
	assign kslot = s_axis_tdata[13:8];
	assign gid = s_axis_tdata[17:14];
	assign doscan = acc && kind == KIND_SCAN && spos_q < 24'(MAX_SCAN_LEN);
	assign act = (kcount_q < 7'(NK)) ? kcount_q : 7'(NK);

	always_comb begin
		ctl.scan = doscan;
		ctl.load = acc && kind == KIND_LOAD;
		ctl.clr = acc && kind == KIND_CLEAR;
		ctl.first = lpos_q == '0;
		ctl.last = s_axis_tlast;
		win_n = {win_q[MAX_KEY_LEN*8-9:0], fold(db)};
		have_n = spos_q + 24'd1;
	end

	// row of keyword cells
	for (genvar k = 0; k < NK; k++) begin : g_cell
		logic h;
		kdm_cell #(.KEY_LEN(MAX_KEY_LEN)) u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(ctl),
			.sel(kslot == 6'(k)), .pos(lpos_q), .data_byte(db), .group_in(gid),
			.window(win_n), .have(have_n), .group_out(grp[k]), .len_out(klen[k]),
			.hit(h)
		);
		assign hits[k] = h && 7'(k) < act;
	end

	// all hits end at this byte: the longest starts earliest, lowest slot
	// breaks the tie; an equal start found later wins only with a lower slot
	always_comb begin
		seen = '0;
		for (int k = 0; k < NK; k++)
			if (hits[k]) seen[klen[k]] = 1'b1;
		clen = '0;
		for (int l = 2; l <= MAX_KEY_LEN; l++)
			if (seen[l]) clen = LW'(l);
		cfound = |hits;
		cslot = '0;
		for (int k = NK - 1; k >= 0; k--)
			if (hits[k] && klen[k] == clen) cslot = 6'(k);
		cstart = 16'(have_n - 24'(clen));
		nfound = bfound_q; nstart = bstart_q; nslot = bslot_q;
		if (doscan && cfound && (!bfound_q || cstart < bstart_q ||
			(cstart == bstart_q && cslot < bslot_q))) begin
			nfound = 1'b1; nstart = cstart; nslot = cslot;
		end
		wgroup = '0;
		for (int k = 0; k < NK; k++)
			if (nslot == 6'(k)) wgroup = grp[k];
	end

	kdm_hits #(.GROUPS(MAX_GROUPS)) u_hits (
		.clk(clk), .arst_n(arst_n), .clr(ctl.clr),
		.inc(acc && kind == KIND_SCAN && s_axis_tlast && nfound),
		.inc_group(wgroup), .rd_group(gid), .rd_count(rcount)
	);

	// control and scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kcount_q <= '0; lpos_q <= '0; win_q <= '0; spos_q <= '0;
			bfound_q <= 1'b0; bstart_q <= '0; bslot_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg_valid) kcount_q <= cfg_data;
			if (ctl.load) begin
				if (s_axis_tlast) lpos_q <= '0;
				else if (lpos_q < LW'(MAX_KEY_LEN)) lpos_q <= lpos_q + 1'b1;
			end
			if (doscan) begin
				win_q <= win_n; spos_q <= have_n;
			end
			bfound_q <= nfound; bstart_q <= nstart; bslot_q <= nslot;
			if (acc && kind == KIND_SCAN && s_axis_tlast) begin
				win_q <= '0; spos_q <= '0; bfound_q <= 1'b0;
				bstart_q <= '0; bslot_q <= '0;
			end
			if (m_axis_tready) ovalid_q <= 1'b0;
			if (acc && ((kind == KIND_SCAN && s_axis_tlast) || kind == KIND_READ))
				ovalid_q <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (acc && kind == KIND_SCAN && s_axis_tlast) begin
			ouser_q <= RES_SCAN;
			odata_q <= {5'd0, 32'd0, nfound ? nstart : 16'd0,
				nfound ? wgroup : 4'd0, nfound ? nslot : 6'd0, nfound};
		end else if (acc && kind == KIND_READ) begin
			ouser_q <= RES_READ;
			odata_q <= {5'd0, (32'(gid) < 32'(MAX_GROUPS)) ? rcount : 32'd0,
				16'd0, gid, 6'd0, 1'b0};
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = odata_q;
	assign m_axis_tuser = ouser_q;
endmodule

// File: sv/kdm_checker.sv
// ----------------------------------------------------------------------------
// kdm_checker
// port-level checks of the keyword dictionary matcher
// ----------------------------------------------------------------------------
`include "keyword_dictionary_matcher_core_macros.svh"
module kdm_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic [1:0] s_axis_tuser,
	input logic s_axis_tlast,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic m_axis_tuser
);
	import kdm_pkg::*;

	// a read word gives a result next cycle
	`KDM_ASSERT(a_read_out, s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_READ |=> m_axis_tvalid && m_axis_tuser == RES_READ, "read word gave no count word")
	// a pending result blocks input while stalled
	`KDM_NEVER(a_stall, m_axis_tvalid && !m_axis_tready && s_axis_tready, "input taken while output stalled")
	// read results never flag a match
	`KDM_ASSERT(a_read_nomatch, m_axis_tvalid && m_axis_tuser == RES_READ |-> !m_axis_tdata[0], "count word flags a match")
endmodule

bind keyword_dictionary_matcher_core kdm_checker u_kdm_checker (.*);

// File: bench/keyword_dictionary_matcher_core_test.sv
// ----------------------------------------------------------------------------
// keyword_dictionary_matcher_core_test
// self-checking bench: keyword loads, buffer scans, counter reads and clears
// are streamed through the matcher and every output word is compared with a
// behavioral model of the dictionary, the scan window and the group counters
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module keyword_dictionary_matcher_core_test;
	import kdm_pkg::*;

	localparam int NKEY = 64;
	localparam int KLEN = 32;
	localparam int NGRP = 16;
	localparam int SLEN = 65536;
	localparam int WATCHDOG = 20000;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic       last;
		logic [5:0] key_slot;
		logic [3:0] group_id;
	} word_in_t;

	typedef struct packed {
		logic        result_kind;
		logic        matched;
		logic [5:0]  match_slot;
		logic [3:0]  match_group;
		logic [15:0] match_offset;
		logic [31:0] hit_count;
	} word_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic m_axis_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [6:0] cfg_data = '0;

	keyword_dictionary_matcher_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// dictionary and scanner copy
	logic [7:0]  kw_byte [NKEY][KLEN];
	int          kw_len [NKEY];
	logic [3:0]  kw_grp [NKEY];
	int          load_pos;
	logic [7:0]  window [KLEN];
	int          scan_pos;
	bit          best_ok;
	int          best_at;
	int          best_kw;
	logic [31:0] hits [NGRP];
	int          active_count;

	word_out_t verdicts[$];
	int  fails = 0;
	int  idle_cycles = 0;
	bit  timed_out = 0;
	int  send_idle = 0;
	int  recv_idle = 0;

	function automatic logic [7:0] lower(logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic void forget_scan();
		foreach (window[i]) window[i] = '0;
		scan_pos = 0;
		best_ok = 0;
		best_at = 0;
		best_kw = 0;
	endfunction

	function automatic void matcher_reset();
		foreach (kw_len[i]) begin
			kw_len[i] = 0;
			kw_grp[i] = '0;
		end
		foreach (kw_byte[i, j]) kw_byte[i][j] = '0;
		foreach (hits[i]) hits[i] = '0;
		load_pos = 0;
		active_count = 0;
		forget_scan();
	endfunction

	// advance the dictionary model by one word, queue any result
	function automatic void predict_word(word_in_t w);
		word_out_t r;
		int n;
		bit ok;
		r = '0;
		case (w.kind)
			KIND_LOAD: begin
				if (load_pos == 0) kw_len[w.key_slot] = 0;
				if (load_pos < KLEN) kw_byte[w.key_slot][load_pos] = w.data_byte;
				kw_grp[w.key_slot] = w.group_id;
				if (load_pos < KLEN) load_pos++;
				if (w.last) begin
					kw_len[w.key_slot] = load_pos >= 2 ? load_pos : 0;
					load_pos = 0;
				end
			end
			KIND_SCAN: begin
				if (scan_pos < SLEN) begin
					for (int i = KLEN - 1; i > 0; i--) window[i] = window[i - 1];
					window[0] = lower(w.data_byte);
					scan_pos++;
					n = active_count < NKEY ? active_count : NKEY;
					for (int k = 0; k < n; k++) begin
						if (kw_len[k] < 2 || kw_len[k] > scan_pos) continue;
						ok = 1;
						for (int i = 0; i < kw_len[k]; i++)
							if (lower(kw_byte[k][i]) != window[kw_len[k] - 1 - i]) ok = 0;
						if (ok && (!best_ok || scan_pos - kw_len[k] < best_at ||
							(scan_pos - kw_len[k] == best_at && k < best_kw))) begin
							best_ok = 1;
							best_at = scan_pos - kw_len[k];
							best_kw = k;
						end
					end
				end
				if (w.last) begin
					r.result_kind = RES_SCAN;
					if (best_ok) begin
						r.matched = 1'b1;
						r.match_slot = 6'(best_kw);
						r.match_group = kw_grp[best_kw];
						r.match_offset = 16'(best_at);
						if (hits[kw_grp[best_kw]] != 32'hffff_ffff)
							hits[kw_grp[best_kw]]++;
					end
					verdicts.push_back(r);
					forget_scan();
				end
			end
			KIND_READ: begin
				r.result_kind = RES_READ;
				r.match_group = w.group_id;
				r.hit_count = hits[w.group_id];
				verdicts.push_back(r);
			end
			default: foreach (hits[i]) hits[i] = '0;
		endcase
	endfunction

	// one word over s_axis with random gaps before it
	task automatic send_word(word_in_t w);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= w.kind;
		s_axis_tlast  <= w.last;
		s_axis_tdata  <= {6'd0, w.group_id, w.key_slot, w.data_byte};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_word(w);
		@(negedge clk);
	endtask

	task automatic write_count(logic [6:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		active_count = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// stop sending, let every pending verdict drain, then wait while the inputs stay quiet
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (verdicts.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic word_in_t mk(logic [1:0] k, logic [7:0] d, logic l,
		logic [5:0] s, logic [3:0] g);
		word_in_t w;
		w = {k, d, l, s, g};
		return w;
	endfunction

	task automatic load_keyword(int slot, int grp, int len, bit tame);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			b = tame ? 8'(($urandom_range(1) ? "a" : "A") + $urandom_range(2)) : 8'($urandom);
			send_word(mk(KIND_LOAD, b, i == len - 1, 6'(slot), 4'(grp)));
		end
	endtask

	task automatic scan_buffer(int len, bit tame);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			b = tame ? 8'(($urandom_range(1) ? "a" : "A") + $urandom_range(2)) : 8'($urandom);
			send_word(mk(KIND_SCAN, b, i == len - 1, 6'($urandom), 4'($urandom)));
		end
	endtask

	// output side: random stall, compare with oldest verdict
	always @(negedge clk) m_axis_tready <= $urandom_range(99) >= recv_idle;

	always @(posedge clk) begin
		word_out_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tuser, m_axis_tdata[0], m_axis_tdata[6:1],
				m_axis_tdata[10:7], m_axis_tdata[26:11], m_axis_tdata[58:27]};
			if (verdicts.size() == 0) begin
				$error("unexpected output word %h", got);
				fails++;
			end else begin
				want = verdicts.pop_front();
				if (got.result_kind !== want.result_kind) begin
					$error("result_kind exp %0d got %0d", want.result_kind, got.result_kind);
					fails++;
				end
				if (got.matched !== want.matched) begin
					$error("matched exp %0d got %0d", want.matched, got.matched);
					fails++;
				end
				if (got.match_slot !== want.match_slot) begin
					$error("match_slot exp %0d got %0d", want.match_slot, got.match_slot);
					fails++;
				end
				if (got.match_group !== want.match_group) begin
					$error("match_group exp %0d got %0d", want.match_group, got.match_group);
					fails++;
				end
				if (got.match_offset !== want.match_offset) begin
					$error("match_offset exp %0d got %0d", want.match_offset,
						got.match_offset);
					fails++;
				end
				if (got.hit_count !== want.hit_count) begin
					$error("hit_count exp %0d got %0d", want.hit_count, got.hit_count);
					fails++;
				end
			end
		end
	end

	// watchdog on cycles with no accepted word anywhere
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG && !timed_out) begin
			timed_out = 1;
			$display("Verification failed");
			$finish;
		end
	end

	// directed rows: kind, byte, last, slot, group, fixed result or none
	typedef struct {
		word_in_t  w;
		bit        fixed;
		word_out_t r;
	} row_t;
	row_t rows[$];

	task automatic run_random(int n);
		int left, slot, pick, len;
		left = n;
		while (left > 0) begin
			pick = $urandom_range(99);
			slot = $urandom_range(NKEY - 1);
			if (pick < 35) begin
				len = $urandom_range(1, 4) + ($urandom_range(19) == 0 ? 34 : 0);
				load_keyword(slot, $urandom_range(NGRP - 1), len, $urandom_range(9) != 0);
				left -= len;
			end else if (pick < 85) begin
				len = $urandom_range(1, 12);
				scan_buffer(len, $urandom_range(9) != 0);
				left -= len;
			end else if (pick < 97) begin
				send_word(mk(KIND_READ, 8'($urandom), 1'($urandom), 6'($urandom),
					4'($urandom)));
				left--;
			end else begin
				send_word(mk(KIND_CLEAR, 8'($urandom), 1'($urandom), 6'($urandom),
					4'($urandom)));
				left--;
			end
		end
	endtask

	initial begin
		row_t x;
		word_out_t z;
		matcher_reset();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		write_count(7'd64);

		// after reset: counters read zero, an empty dictionary never matches
		z = '0; z.result_kind = RES_READ; z.match_group = 4'hf;
		x.w = mk(KIND_READ, 8'hff, 1'b1, 6'h3f, 4'hf); x.fixed = 1; x.r = z; rows.push_back(x);
		z = '0;
		x.w = mk(KIND_SCAN, 8'h00, 1'b1, 6'h00, 4'h0); x.fixed = 1; x.r = z; rows.push_back(x);
		// dictionary ends at slots 0 and 63; one-byte keyword stays unused; overlong truncated
		x.fixed = 0; x.r = '0;
		x.w = mk(KIND_LOAD, "Z", 1'b1, 6'd0, 4'd1); rows.push_back(x);
		x.w = mk(KIND_LOAD, "a", 1'b0, 6'd63, 4'd15); rows.push_back(x);
		x.w = mk(KIND_LOAD, "B", 1'b1, 6'd63, 4'd15); rows.push_back(x);
		x.w = mk(KIND_LOAD, "A", 1'b0, 6'd5, 4'd2); rows.push_back(x);
		x.w = mk(KIND_LOAD, "b", 1'b1, 6'd5, 4'd2); rows.push_back(x);
		for (int i = 0; i < 40; i++) begin
			x.w = mk(KIND_LOAD, 8'(($urandom_range(1) ? "a" : "A") + $urandom_range(2)),
				i == 39, 6'd7, 4'd3);
			rows.push_back(x);
		end
		// "ab" at offset 2 matches slots 5 and 63, the lower slot wins
		x.w = mk(KIND_SCAN, "z", 1'b0, 6'd0, 4'd0); rows.push_back(x);
		x.w = mk(KIND_SCAN, 8'hff, 1'b0, 6'd0, 4'd0); rows.push_back(x);
		x.w = mk(KIND_SCAN, "A", 1'b0, 6'd0, 4'd0); rows.push_back(x);
		x.w = mk(KIND_SCAN, "b", 1'b1, 6'd0, 4'd0); rows.push_back(x);
		x.w = mk(KIND_READ, 8'd0, 1'b0, 6'd0, 4'd2); rows.push_back(x);
		x.w = mk(KIND_CLEAR, 8'd0, 1'b0, 6'd0, 4'd0); rows.push_back(x);
		x.w = mk(KIND_READ, 8'd0, 1'b0, 6'd0, 4'd2); rows.push_back(x);
		// same start: the longer keyword ends later but its lower slot wins
		x.w = mk(KIND_LOAD, "c", 1'b0, 6'd10, 4'd4); rows.push_back(x);
		x.w = mk(KIND_LOAD, "D", 1'b1, 6'd10, 4'd4); rows.push_back(x);
		x.w = mk(KIND_LOAD, "C", 1'b0, 6'd8, 4'd6); rows.push_back(x);
		x.w = mk(KIND_LOAD, "d", 1'b0, 6'd8, 4'd6); rows.push_back(x);
		x.w = mk(KIND_LOAD, "c", 1'b1, 6'd8, 4'd6); rows.push_back(x);
		x.w = mk(KIND_SCAN, "c", 1'b0, 6'd0, 4'd0); rows.push_back(x);
		x.w = mk(KIND_SCAN, "d", 1'b0, 6'd0, 4'd0); rows.push_back(x);
		x.w = mk(KIND_SCAN, "C", 1'b1, 6'd0, 4'd0); rows.push_back(x);
		x.w = mk(KIND_READ, 8'd0, 1'b0, 6'd0, 4'd6); rows.push_back(x);
		foreach (rows[i]) begin
			send_word(rows[i].w);
			if (rows[i].fixed && verdicts.size() != 0 && verdicts[$] != rows[i].r) begin
				$error("directed row %0d verdict exp %h got %h", i, rows[i].r, verdicts[$]);
				fails++;
			end
		end
		// sender waits for every verdict before going on
		drain();
		write_count(7'd127);
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle = phase == 0 ? 19 : phase == 1 ? 64 : 0;
			recv_idle = phase == 0 ? 64 : phase == 1 ? 19 : 0;
			run_random(360);
			drain();
			write_count(phase == 0 ? 7'd0 : phase == 1 ? 7'd9 : 7'd64);
		end
		run_random(30);
		drain();

		if (fails == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
